FILE: sv/oale_pkg.sv
package oale_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OPC_W          = 3;
    localparam int POS_W          = 7;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_READ   = 3'd3,
        OP_FIND   = 3'd4,
        OP_PRED   = 3'd5,
        OP_SUCC   = 3'd6
    } op_t;

    // shift request broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
    } shift_ctrl_t;

    // lookup token travelling down the chain
    typedef struct packed {
        logic valid;
        logic hit;
    } tok_ctrl_t;

endpackage

FILE: sv/oale_cell.sv
module oale_cell #(
    parameter int IDX        = 0,
    parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF,
    parameter int PW         = 8,
    parameter int IW         = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  oale_pkg::shift_ctrl_t        ctrl,
    input  logic [PW-1:0]                shift_idx,
    input  logic signed [DATA_WIDTH-1:0] ins_value,
    input  logic signed [DATA_WIDTH-1:0] left,
    input  logic signed [DATA_WIDTH-1:0] right,
    input  logic                         find_mode,
    input  logic [PW-1:0]                tgt,
    input  logic [PW-1:0]                cnt,
    input  logic signed [DATA_WIDTH-1:0] key,
    input  oale_pkg::tok_ctrl_t          tok_in,
    input  logic signed [DATA_WIDTH-1:0] tok_data_in,
    input  logic [IW-1:0]                tok_fpos_in,
    output logic signed [DATA_WIDTH-1:0] entry,
    output oale_pkg::tok_ctrl_t          tok_out,
    output logic signed [DATA_WIDTH-1:0] tok_data_out,
    output logic [IW-1:0]                tok_fpos_out
);

    localparam logic [PW-1:0] ME = PW'(IDX);
    localparam logic [IW-1:0] FP = IW'(IDX + 1);

    logic signed [DATA_WIDTH-1:0] entry_reg, entry_next;
    oale_pkg::tok_ctrl_t          tok_reg, tok_next;
    logic signed [DATA_WIDTH-1:0] tdata_reg, tdata_next;
    logic [IW-1:0]                tfpos_reg, tfpos_next;
    logic                         match;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (ME == shift_idx)
                entry_next = ins_value;
            else if (ME > shift_idx)
                entry_next = left;
        end
        else if (ctrl.del)
        begin
            if (ME >= shift_idx)
                entry_next = right;
        end
    end

    always_comb
    begin
        match      = find_mode ? ((ME < cnt) && (entry_reg == key)) : (ME == tgt);
        tok_next   = tok_in;
        tdata_next = tok_data_in;
        tfpos_next = tok_fpos_in;
        // first matching cell claims the token
        if (tok_in.valid && !tok_in.hit && match)
        begin
            tok_next.hit = 1'b1;
            tdata_next   = entry_reg;
            tfpos_next   = FP;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        tdata_reg <= tdata_next;
        tfpos_reg <= tfpos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    assign entry        = entry_reg;
    assign tok_out      = tok_reg;
    assign tok_data_out = tdata_reg;
    assign tok_fpos_out = tfpos_reg;

endmodule

FILE: sv/ordered_array_list_engine_unit.sv
// Positional list of up to CAPACITY signed values held in a row of cells, one entry per
// cell. A request is taken when start is high and busy is low. Clear, insert, delete,
// any rejected request and find on an empty list give their result (done high for one
// cycle) in the cycle after the request; insert and delete move every entry from the
// given position onward one cell, all at once. Read, find, predecessor and successor
// send a lookup token down the chain one cell per clock; the result is registered
// from the token leaving the last cell, and busy stays high meanwhile. Results cannot be
// held off: sample them whenever done is high.
module ordered_array_list_engine_unit #(
    parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [oale_pkg::OPC_W-1:0]       opcode,
    input  logic [oale_pkg::POS_W-1:0]       position,
    input  logic signed [DATA_WIDTH-1:0]     value,
    output logic                             busy,
    output logic                             done,
    output logic                             status,
    output logic signed [DATA_WIDTH-1:0]     data_out,
    output logic [oale_pkg::POS_W-1:0]       found_position,
    output logic [oale_pkg::POS_W-1:0]       list_length,
    output logic                             is_empty
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam int PW = ((IW > oale_pkg::POS_W) ? IW : oale_pkg::POS_W) + 1;

    logic [IW-1:0]                count_reg, count_next;
    logic                         scan_reg, scan_next;
    logic                         inject_reg, inject_next;
    logic                         find_reg;
    logic [PW-1:0]                tgt_reg;
    logic signed [DATA_WIDTH-1:0] key_reg;

    logic                         done_reg, done_next;
    logic                         status_reg, status_next;
    logic signed [DATA_WIDTH-1:0] data_reg, data_next;
    logic [oale_pkg::POS_W-1:0]   fpos_reg, fpos_next;
    logic [oale_pkg::POS_W-1:0]   len_reg, len_next;
    logic                         empty_reg, empty_next;

    logic                         accept;
    oale_pkg::op_t                op;
    logic [PW-1:0]                pos_x, cnt_x, shift_idx, tgt_next;
    logic                         ok, go_scan, is_find;
    oale_pkg::shift_ctrl_t        shift_ctrl;

    logic signed [DATA_WIDTH-1:0] entry_w [CAPACITY];
    oale_pkg::tok_ctrl_t          tok_w   [CAPACITY+1];
    logic signed [DATA_WIDTH-1:0] tdata_w [CAPACITY+1];
    logic [IW-1:0]                tfpos_w [CAPACITY+1];

    assign accept    = start && !scan_reg;
    assign op        = oale_pkg::op_t'(opcode);
    assign pos_x     = PW'(position);
    assign cnt_x     = PW'(count_reg);
    assign shift_idx = pos_x - PW'(1);

    always_comb
    begin
        ok       = 1'b0;
        go_scan  = 1'b0;
        is_find  = 1'b0;
        tgt_next = pos_x;
        case (op)
            oale_pkg::OP_CLEAR:
                ok = 1'b1;
            oale_pkg::OP_INSERT:
                ok = (pos_x != '0) && (pos_x <= cnt_x + PW'(1)) && (cnt_x < PW'(CAPACITY));
            oale_pkg::OP_DELETE:
                ok = (pos_x != '0) && (pos_x <= cnt_x);
            oale_pkg::OP_READ:
            begin
                ok       = (pos_x != '0) && (pos_x <= cnt_x);
                go_scan  = ok;
                tgt_next = pos_x - PW'(1);
            end
            oale_pkg::OP_FIND:
            begin
                is_find = 1'b1;
                go_scan = (cnt_x != '0);
            end
            oale_pkg::OP_PRED:
            begin
                ok       = (pos_x > PW'(1)) && (pos_x <= cnt_x);
                go_scan  = ok;
                tgt_next = pos_x - PW'(2);
            end
            oale_pkg::OP_SUCC:
            begin
                ok       = (pos_x != '0) && (pos_x < cnt_x);
                go_scan  = ok;
                tgt_next = pos_x;
            end
            default:
                ok = 1'b0;
        endcase
    end

    always_comb
    begin
        shift_ctrl.ins = accept && (op == oale_pkg::OP_INSERT) && ok;
        shift_ctrl.del = accept && (op == oale_pkg::OP_DELETE) && ok;

        count_next = count_reg;
        if (accept && (op == oale_pkg::OP_CLEAR))
            count_next = '0;
        else if (shift_ctrl.ins)
            count_next = count_reg + IW'(1);
        else if (shift_ctrl.del)
            count_next = count_reg - IW'(1);

        inject_next = accept && go_scan;
        scan_next   = scan_reg;
        if (accept && go_scan)
            scan_next = 1'b1;
        else if (tok_w[CAPACITY].valid)
            scan_next = 1'b0;
    end

    always_comb
    begin
        done_next   = 1'b0;
        status_next = 1'b1;
        data_next   = '0;
        fpos_next   = '0;
        if (accept && !go_scan)
        begin
            done_next   = 1'b1;
            status_next = !ok;
        end
        else if (tok_w[CAPACITY].valid)
        begin
            done_next   = 1'b1;
            status_next = !tok_w[CAPACITY].hit;
            if (find_reg)
                fpos_next = oale_pkg::POS_W'(tfpos_w[CAPACITY]);
            else
                data_next = tdata_w[CAPACITY];
        end
        len_next   = oale_pkg::POS_W'(count_next);
        empty_next = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            scan_reg   <= 1'b0;
            inject_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            scan_reg   <= scan_next;
            inject_reg <= inject_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            find_reg <= is_find;
            tgt_reg  <= tgt_next;
            key_reg  <= value;
        end
        status_reg <= status_next;
        data_reg   <= data_next;
        fpos_reg   <= fpos_next;
        len_reg    <= len_next;
        empty_reg  <= empty_next;
    end

    // token enters the first cell in the cycle after the request, once key and target are held
    assign tok_w[0].valid = inject_reg;
    assign tok_w[0].hit   = 1'b0;
    assign tdata_w[0]     = '0;
    assign tfpos_w[0]     = '0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] left_w, right_w;
        if (k == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_mid_l
            assign left_w = entry_w[k-1];
        end
        if (k == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_mid_r
            assign right_w = entry_w[k+1];
        end

        oale_cell #(
            .IDX        (k),
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW),
            .IW         (IW)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (shift_ctrl),
            .shift_idx    (shift_idx),
            .ins_value    (value),
            .left         (left_w),
            .right        (right_w),
            .find_mode    (find_reg),
            .tgt          (tgt_reg),
            .cnt          (cnt_x),
            .key          (key_reg),
            .tok_in       (tok_w[k]),
            .tok_data_in  (tdata_w[k]),
            .tok_fpos_in  (tfpos_w[k]),
            .entry        (entry_w[k]),
            .tok_out      (tok_w[k+1]),
            .tok_data_out (tdata_w[k+1]),
            .tok_fpos_out (tfpos_w[k+1])
        );
    end

    assign busy           = scan_reg;
    assign done           = done_reg;
    assign status         = status_reg;
    assign data_out       = data_reg;
    assign found_position = fpos_reg;
    assign list_length    = len_reg;
    assign is_empty       = empty_reg;

endmodule

FILE: sv/oale_checker.sv
module oale_checker #(
    parameter int DATA_WIDTH = oale_pkg::DATA_WIDTH_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic [oale_pkg::OPC_W-1:0]   opcode,
    input logic [oale_pkg::POS_W-1:0]   position,
    input logic signed [DATA_WIDTH-1:0] value,
    input logic                         busy,
    input logic                         done,
    input logic                         status,
    input logic signed [DATA_WIDTH-1:0] data_out,
    input logic [oale_pkg::POS_W-1:0]   found_position,
    input logic [oale_pkg::POS_W-1:0]   list_length,
    input logic                         is_empty
);

    // no result may appear while a lookup is in flight
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result strobe while busy");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (is_empty == (list_length == '0)))
        else $error("empty flag disagrees with length");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (opcode == oale_pkg::OP_CLEAR))
        |=> (done && !status && (list_length == '0)))
        else $error("clear request did not empty the list");

    a_shift_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((opcode == oale_pkg::OP_INSERT) || (opcode == oale_pkg::OP_DELETE)))
        |=> done)
        else $error("insert or delete result late");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> ((data_out == '0) && (found_position == '0)))
        else $error("failed request carries data");

endmodule

bind ordered_array_list_engine_unit oale_checker #(.DATA_WIDTH(DATA_WIDTH)) u_oale_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import oale_pkg::*;

    localparam int CAP        = CAPACITY_DEF;
    localparam int DW         = DATA_WIDTH_DEF;
    localparam int QUIET_MAX  = 2000;
    localparam int DRAIN_WAIT = CAP + 8;
    localparam logic [OPC_W-1:0] OP_UNUSED = 3'd7;

    typedef struct packed {
        logic                 status;
        logic signed [DW-1:0] data;
        logic [POS_W-1:0]     fpos;
        logic [POS_W-1:0]     len;
        logic                 empty;
    } list_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic [OPC_W-1:0]     opcode = '0;
    logic [POS_W-1:0]     position = '0;
    logic signed [DW-1:0] value = '0;
    logic                 busy;
    logic                 done;
    logic                 status;
    logic signed [DW-1:0] data_out;
    logic [POS_W-1:0]     found_position;
    logic [POS_W-1:0]     list_length;
    logic                 is_empty;

    // shadow copy of the list
    logic signed [DW-1:0] list_mem [0:CAP-1];
    int                   list_count = 0;

    list_result_t expected_results[$];
    bit           idle_on = 1'b1;
    int           failures = 0;
    int           requests_sent = 0;
    int           requests_rejected = 0;
    int           results_checked = 0;
    int           peak_len = 0;
    int           quiet_cycles = 0;

    ordered_array_list_engine_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .opcode         (opcode),
        .position       (position),
        .value          (value),
        .busy           (busy),
        .done           (done),
        .status         (status),
        .data_out       (data_out),
        .found_position (found_position),
        .list_length    (list_length),
        .is_empty       (is_empty)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic list_result_t list_apply(input logic [OPC_W-1:0] op,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [DW-1:0] val);
        list_result_t r;
        int p;
        int n;
        int i;
        p = pos;
        n = list_count;
        r = '0;
        r.status = 1'b1;
        case (op)
            OP_CLEAR:
            begin
                n = 0;
                r.status = 1'b0;
            end
            OP_INSERT:
                if (p >= 1 && p <= n + 1 && n < CAP)
                begin
                    for (i = n; i >= p; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[p-1] = val;
                    n++;
                    r.status = 1'b0;
                end
            OP_DELETE:
                if (p >= 1 && p <= n)
                begin
                    for (i = p; i < n; i++)
                        list_mem[i-1] = list_mem[i];
                    n--;
                    r.status = 1'b0;
                end
            OP_READ:
                if (p >= 1 && p <= n)
                begin
                    r.data = list_mem[p-1];
                    r.status = 1'b0;
                end
            OP_FIND:
                for (i = 0; i < n; i++)
                    if (r.status && list_mem[i] == val)
                    begin
                        r.fpos = POS_W'(i + 1);
                        r.status = 1'b0;
                    end
            OP_PRED:
                if (p > 1 && p <= n)
                begin
                    r.data = list_mem[p-2];
                    r.status = 1'b0;
                end
            OP_SUCC:
                if (p >= 1 && p < n)
                begin
                    r.data = list_mem[p];
                    r.status = 1'b0;
                end
            default: ;
        endcase
        list_count = n;
        r.len = POS_W'(n);
        r.empty = (n == 0);
        return r;
    endfunction

    // extremes and small values often, so that duplicates turn up in the list
    function automatic logic signed [DW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return {1'b1, {(DW-1){1'b0}}};
            1: return {1'b0, {(DW-1){1'b1}}};
            2, 3: return $signed($urandom_range(0, 7)) - 3;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_req(input logic [OPC_W-1:0] op, input int pos,
                            input logic signed [DW-1:0] val);
        int gap;
        list_result_t r;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        opcode   <= op;
        position <= pos[POS_W-1:0];
        value    <= val;
        do @(posedge clk); while (busy);
        r = list_apply(op, pos[POS_W-1:0], val);
        expected_results.push_back(r);
        requests_sent++;
        if (r.status)
            requests_rejected++;
        if (list_count > peak_len)
            peak_len = list_count;
    endtask

    task automatic test_directed();
        send_req(OP_CLEAR, 0, 0);
        send_req(OP_READ, 1, 0);
        send_req(OP_FIND, 0, 0);
        send_req(OP_DELETE, 1, 0);
        send_req(OP_PRED, 1, 0);
        send_req(OP_INSERT, 0, 5);
        send_req(OP_INSERT, 2, 5);
        send_req(OP_INSERT, 1, 32'sh7fffffff);
        send_req(OP_INSERT, 1, 32'sh80000000);
        send_req(OP_INSERT, 3, 0);
        send_req(OP_INSERT, 2, -1);
        send_req(OP_READ, 4, 0);
        send_req(OP_READ, 5, 0);
        send_req(OP_PRED, 1, 0);
        send_req(OP_PRED, 4, 0);
        send_req(OP_SUCC, 4, 0);
        send_req(OP_SUCC, 1, 0);
        send_req(OP_FIND, 0, 32'sh7fffffff);
        send_req(OP_FIND, 0, 12345);
        send_req(OP_INSERT, 1, -1);
        send_req(OP_FIND, 0, -1);      // duplicate: first match wins
        send_req(OP_DELETE, 3, 0);
        send_req(OP_DELETE, 0, 0);
        send_req(OP_READ, 127, -1);
        send_req(OP_UNUSED, 1, -1);
        send_req(OP_DELETE, 4, 0);
        send_req(OP_CLEAR, 0, 0);
    endtask

    // fill to capacity, probe the far end, then drain
    task automatic test_fill_and_drain();
        send_req(OP_CLEAR, 0, 0);
        while (list_count < CAP)
        begin
            send_req(OP_INSERT, $urandom_range(1, list_count + 1), rand_value());
            if ($urandom_range(0, 7) == 0)
                send_req(OP_READ, $urandom_range(1, list_count), 0);
        end
        send_req(OP_INSERT, $urandom_range(1, CAP + 1), rand_value());
        send_req(OP_READ, CAP, 0);
        send_req(OP_PRED, CAP, 0);
        send_req(OP_SUCC, CAP - 1, 0);
        send_req(OP_SUCC, CAP, 0);
        send_req(OP_FIND, 0, list_mem[CAP-1]);
        send_req(OP_DELETE, CAP, 0);
        send_req(OP_DELETE, 1, 0);
        while (list_count > 0)
        begin
            send_req(OP_DELETE, $urandom_range(1, list_count), 0);
            if ($urandom_range(0, 7) == 0)
                send_req(OP_FIND, 0, rand_value());
        end
    endtask

    task automatic test_random_mix(input int num_reqs);
        int k;
        int r;
        int n;
        int lo;
        int hi;
        int pos;
        int ins_w;
        int del_w;
        int fill_target;
        logic [OPC_W-1:0] op;
        logic signed [DW-1:0] val;
        fill_target = CAP / 2;
        for (k = 0; k < num_reqs; k++)
        begin
            if (k % 50 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (k % 80 == 0)
                fill_target = ($urandom_range(0, 3) == 0) ? CAP : $urandom_range(0, CAP);
            n = list_count;
            if (n < fill_target)
            begin
                ins_w = 35;
                del_w = 8;
            end
            else
            begin
                ins_w = 8;
                del_w = 35;
            end
            r = $urandom_range(0, 99);
            if (r >= 95)
            begin
                // noise: anything the fields allow
                send_req(OPC_W'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom);
                continue;
            end
            if (r < 1)
                op = OP_CLEAR;
            else if (r < 1 + ins_w)
                op = OP_INSERT;
            else if (r < 1 + ins_w + del_w)
                op = OP_DELETE;
            else
                case ($urandom_range(0, 3))
                    0: op = OP_READ;
                    1: op = OP_FIND;
                    2: op = OP_PRED;
                    default: op = OP_SUCC;
                endcase
            lo = 1;
            case (op)
                OP_INSERT: hi = n + 1;
                OP_PRED:
                begin
                    lo = 2;
                    hi = n;
                end
                OP_SUCC: hi = n - 1;
                default: hi = n;
            endcase
            if (hi >= lo && $urandom_range(0, 9) != 0)
                pos = $urandom_range(lo, hi);
            else
                case ($urandom_range(0, 2))
                    0: pos = 0;
                    1: pos = hi + 1;
                    default: pos = $urandom_range(0, 127);
                endcase
            if (op == OP_FIND && n > 0 && $urandom_range(0, 2) != 0)
                val = list_mem[$urandom_range(0, n - 1)];
            else
                val = rand_value();
            send_req(op, pos, val);
        end
        idle_on = 1'b1;
    endtask

    // every strobe is one result: compare it with the oldest outstanding request
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with no request outstanding");
                failures++;
            end
            else
            begin
                exp_r = expected_results.pop_front();
                results_checked++;
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    failures++;
                end
                if (data_out !== exp_r.data)
                begin
                    $error("data_out: expected %0d, got %0d", exp_r.data, data_out);
                    failures++;
                end
                if (found_position !== exp_r.fpos)
                begin
                    $error("found_position: expected %0d, got %0d",
                           exp_r.fpos, found_position);
                    failures++;
                end
                if (list_length !== exp_r.len)
                begin
                    $error("list_length: expected %0d, got %0d", exp_r.len, list_length);
                    failures++;
                end
                if (is_empty !== exp_r.empty)
                begin
                    $error("is_empty: expected %0d, got %0d", exp_r.empty, is_empty);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_MAX)
        begin
            $display("timeout: nothing moved for %0d cycles", QUIET_MAX);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_and_drain();
        test_random_mix(975);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("%0d requests (%0d rejected), %0d results checked, list peaked at %0d of %0d",
                 requests_sent, requests_rejected, results_checked, peak_len, CAP);
        $display("every opcode incl. the unused one, fill to capacity and drain, bad positions");
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
